// ===== sv/tct_pkg.sv =====
// Shared types, codes and constants of the TCP connection tracker.
// No dependencies; imported by the top level, the checker and the testbench.
package tct_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  TCP_PROTOCOL   = 8'd6;
   localparam logic [15:0] TIMEOUT_RESET  = 16'd240;

   localparam logic [2:0] STATUS_EXISTING = 3'd0;
   localparam logic [2:0] STATUS_CREATED  = 3'd1;
   localparam logic [2:0] STATUS_FULL     = 3'd2;
   localparam logic [2:0] STATUS_IGNORED  = 3'd3;
   localparam logic [2:0] STATUS_TICK     = 3'd4;

   localparam logic [2:0] CONN_UNKNOWN     = 3'd0;
   localparam logic [2:0] CONN_SYN_SENT    = 3'd1;
   localparam logic [2:0] CONN_SYN_RECV    = 3'd2;
   localparam logic [2:0] CONN_ESTABLISHED = 3'd3;
   localparam logic [2:0] CONN_FIN_WAIT1   = 3'd4;
   localparam logic [2:0] CONN_FIN_WAIT2   = 3'd5;
   localparam logic [2:0] CONN_LAST_ACK    = 3'd6;
   localparam logic [2:0] CONN_CLOSED      = 3'd7;

   localparam int FLAG_SYN = 0;
   localparam int FLAG_ACK = 1;
   localparam int FLAG_FIN = 2;
   localparam int FLAG_RST = 3;

   typedef struct packed {
      logic [31:0] addr_a;
      logic [31:0] addr_b;
      logic [15:0] port_a;
      logic [15:0] port_b;
      logic [2:0]  conn_state;
      logic [31:0] last_seen;
      logic [31:0] packets;
      logic [31:0] bytes;
   } entry_type;

   function automatic logic [2:0] next_conn_state(input logic [2:0] st, input logic [3:0] f);
      logic syn;
      logic ack;
      logic fin;
      logic rst;
      logic [2:0] nst;
      syn = f[FLAG_SYN];
      ack = f[FLAG_ACK];
      fin = f[FLAG_FIN];
      rst = f[FLAG_RST];
      unique case (st)
         CONN_SYN_SENT: begin
            nst = (syn && ack) ? CONN_SYN_RECV : CONN_CLOSED;
         end
         CONN_SYN_RECV: begin
            nst = (ack && !syn && !fin && !rst) ? CONN_ESTABLISHED : CONN_CLOSED;
         end
         CONN_ESTABLISHED: begin
            if (rst) nst = CONN_CLOSED;
            else if (fin) nst = CONN_FIN_WAIT1;
            else nst = CONN_ESTABLISHED;
         end
         CONN_FIN_WAIT1: begin
            if (ack && !fin) nst = CONN_FIN_WAIT2;
            else if (ack && fin) nst = CONN_LAST_ACK;
            else nst = CONN_CLOSED;
         end
         CONN_FIN_WAIT2: begin
            nst = fin ? CONN_LAST_ACK : CONN_CLOSED;
         end
         CONN_LAST_ACK: begin
            nst = ack ? CONN_CLOSED : CONN_LAST_ACK;
         end
         CONN_CLOSED: begin
            nst = CONN_CLOSED;
         end
         default: begin
            if (syn && ack) nst = CONN_SYN_RECV;
            else if (syn) nst = CONN_SYN_SENT;
            else if (fin) nst = CONN_FIN_WAIT1;
            else if (rst) nst = CONN_CLOSED;
            else nst = CONN_ESTABLISHED;
         end
      endcase
      return nst;
   endfunction

endpackage

// ===== sv/tct_if.sv =====
// Valid/ready channel interfaces of the TCP connection tracker:
// request beats, response beats and the timeout register write.
interface tct_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] ether_type;
   logic [7:0]  ip_protocol;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic [15:0] src_port;
   logic [15:0] dst_port;
   logic [15:0] total_length;
   logic [3:0]  ip_header_words;
   logic [3:0]  tcp_header_words;
   logic [3:0]  tcp_flags;

   modport source (
      output valid, kind, ether_type, ip_protocol, src_addr, dst_addr, src_port, dst_port,
             total_length, ip_header_words, tcp_header_words, tcp_flags,
      input  ready
   );
   modport sink (
      input  valid, kind, ether_type, ip_protocol, src_addr, dst_addr, src_port, dst_port,
             total_length, ip_header_words, tcp_header_words, tcp_flags,
      output ready
   );
endinterface

interface tct_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [5:0]  entry_index;
   logic [2:0]  conn_state;
   logic [31:0] packet_count;
   logic [31:0] byte_count;
   logic [6:0]  expired_count;

   modport source (
      output valid, status, entry_index, conn_state, packet_count, byte_count, expired_count,
      input  ready
   );
   modport sink (
      input  valid, status, entry_index, conn_state, packet_count, byte_count, expired_count,
      output ready
   );
endinterface

interface tct_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] timeout_seconds;

   modport source (output valid, timeout_seconds, input ready);
   modport sink (input valid, timeout_seconds, output ready);
endinterface

// ===== sv/tct_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module tct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/tcp_connection_tracker.sv =====
// TCP connection tracker top level; uses tct_pkg, tct_if and tct_ram.
// A hit ends the slot scan at its slot, a miss or a tick scans all TABLE_ENTRIES slots,
// and a non-TCP packet skips the scan and goes straight to the response.
// One request in flight; the next request beat can be taken in the same cycle that the
// response is raised. The scan of the session RAM reads one slot per cycle.
// Reset (synchronous): clears slot valid bits, time, response valid bit; timeout to 240.
// Session RAM needs no clearing pass.
module tcp_connection_tracker (
   input logic        clock,
   input logic        reset,
   tct_req_if.sink    req_if,
   tct_rsp_if.source  rsp_if,
   tct_csr_if.sink    csr_if
);
   import tct_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_UPD  = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic                     kind_ff, kind_in;
   logic [3:0]               flags_ff, flags_in;
   logic [31:0]              sa_ff, sa_in, da_ff, da_in;
   logic [15:0]              sp_ff, sp_in, dp_ff, dp_in;
   logic [31:0]              payload_ff, payload_in;
   logic [31:0]              time_ff, time_in;
   logic [15:0]              timeout_ff, timeout_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]         issue_ff, issue_in;
   logic                     cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                     free_found_ff, free_found_in;
   logic [IDX_W-1:0]         free_slot_ff, free_slot_in;
   logic [CNT_W-1:0]         exp_cnt_ff, exp_cnt_in;
   logic [IDX_W-1:0]         slot_ff, slot_in;
   logic                     created_ff, created_in;
   entry_type                hit_ff, hit_in;
   logic [2:0]               res_status_ff, res_status_in;
   logic [2:0]               res_state_ff, res_state_in;
   logic [31:0]              res_packets_ff, res_packets_in;
   logic [31:0]              res_bytes_ff, res_bytes_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [2:0]               rsp_status_ff, rsp_status_in;
   logic [5:0]               rsp_index_ff, rsp_index_in;
   logic [2:0]               rsp_state_ff, rsp_state_in;
   logic [31:0]              rsp_packets_ff, rsp_packets_in;
   logic [31:0]              rsp_bytes_ff, rsp_bytes_in;
   logic [6:0]               rsp_expired_ff, rsp_expired_in;

   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   entry_type        ram_wr_data;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   entry_type        ram_rd_data;

   logic        req_beat;
   logic [4:0]  hdr_words;
   logic        slot_valid;
   logic        slot_last;
   logic        addr_ok;
   logic        port_ok;
   logic [31:0] idle_time;
   logic        stale;
   entry_type   base;
   logic [2:0]  new_state;
   logic        count_it;

   tct_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_beat     = req_if.valid && (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.entry_index   = rsp_index_ff;
   assign rsp_if.conn_state    = rsp_state_ff;
   assign rsp_if.packet_count  = rsp_packets_ff;
   assign rsp_if.byte_count    = rsp_bytes_ff;
   assign rsp_if.expired_count = rsp_expired_ff;

   assign hdr_words  = {1'b0, req_if.ip_header_words} + {1'b0, req_if.tcp_header_words};
   assign slot_valid = valid_ff[cmp_idx_ff];
   assign slot_last  = (cmp_idx_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign addr_ok    = (ram_rd_data.addr_a == sa_ff && ram_rd_data.addr_b == da_ff) ||
                       (ram_rd_data.addr_a == da_ff && ram_rd_data.addr_b == sa_ff);
   assign port_ok    = (ram_rd_data.port_a == sp_ff && ram_rd_data.port_b == dp_ff) ||
                       (ram_rd_data.port_a == dp_ff && ram_rd_data.port_b == sp_ff);
   assign idle_time  = time_ff - ram_rd_data.last_seen;
   assign stale      = idle_time > {16'b0, timeout_ff};

   always_comb begin
      if (created_ff) begin
         base.addr_a     = sa_ff;
         base.addr_b     = da_ff;
         base.port_a     = sp_ff;
         base.port_b     = dp_ff;
         base.conn_state = CONN_UNKNOWN;
         base.last_seen  = time_ff;
         base.packets    = 32'd0;
         base.bytes      = 32'd0;
      end else begin
         base = hit_ff;
      end
   end

   assign new_state = next_conn_state(base.conn_state, flags_ff);
   assign count_it  = (base.conn_state == CONN_ESTABLISHED) && !flags_ff[FLAG_RST];

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      flags_in       = flags_ff;
      sa_in          = sa_ff;
      da_in          = da_ff;
      sp_in          = sp_ff;
      dp_in          = dp_ff;
      payload_in     = payload_ff;
      time_in        = time_ff;
      timeout_in     = timeout_ff;
      valid_in       = valid_ff;
      issue_in       = issue_ff;
      cmp_valid_in   = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      free_found_in  = free_found_ff;
      free_slot_in   = free_slot_ff;
      exp_cnt_in     = exp_cnt_ff;
      slot_in        = slot_ff;
      created_in     = created_ff;
      hit_in         = hit_ff;
      res_status_in  = res_status_ff;
      res_state_in   = res_state_ff;
      res_packets_in = res_packets_ff;
      res_bytes_in   = res_bytes_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_state_in   = rsp_state_ff;
      rsp_packets_in = rsp_packets_ff;
      rsp_bytes_in   = rsp_bytes_ff;
      rsp_expired_in = rsp_expired_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = slot_ff;
      ram_wr_data    = base;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = issue_ff[IDX_W-1:0];

      if (csr_if.valid) begin
         timeout_in = csr_if.timeout_seconds;
      end

      // drop the response beat once taken
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               kind_in        = req_if.kind;
               flags_in       = req_if.tcp_flags;
               sa_in          = req_if.src_addr;
               da_in          = req_if.dst_addr;
               sp_in          = req_if.src_port;
               dp_in          = req_if.dst_port;
               payload_in     = {16'b0, req_if.total_length} - {25'b0, hdr_words, 2'b00};
               issue_in       = '0;
               free_found_in  = 1'b0;
               exp_cnt_in     = '0;
               res_state_in   = CONN_UNKNOWN;
               res_packets_in = 32'd0;
               res_bytes_in   = 32'd0;
               if (req_if.kind) begin
                  time_in  = time_ff + 32'd1;
                  state_in = S_SCAN;
               end else if (req_if.ether_type != ETHERTYPE_IPV4 ||
                            req_if.ip_protocol != TCP_PROTOCOL) begin
                  res_status_in = STATUS_IGNORED;
                  state_in      = S_FIN;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (issue_ff < CNT_W'(TABLE_ENTRIES)) begin
               ram_rd_en    = 1'b1;
               issue_in     = issue_ff + CNT_W'(1);
               cmp_valid_in = 1'b1;
               cmp_idx_in   = issue_ff[IDX_W-1:0];
            end
            if (cmp_valid_ff) begin
               if (kind_ff) begin
                  if (slot_valid && stale) begin
                     valid_in[cmp_idx_ff] = 1'b0;
                     exp_cnt_in           = exp_cnt_ff + CNT_W'(1);
                  end
                  if (slot_last) begin
                     res_status_in = STATUS_TICK;
                     state_in      = S_FIN;
                  end
               end else if (slot_valid && addr_ok && port_ok) begin
                  slot_in    = cmp_idx_ff;
                  created_in = 1'b0;
                  hit_in     = ram_rd_data;
                  state_in   = S_UPD;
               end else begin
                  if (!slot_valid && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_slot_in  = cmp_idx_ff;
                  end
                  if (slot_last) begin
                     if (free_found_ff) begin
                        slot_in    = free_slot_ff;
                        created_in = 1'b1;
                        state_in   = S_UPD;
                     end else if (!slot_valid) begin
                        slot_in    = cmp_idx_ff;
                        created_in = 1'b1;
                        state_in   = S_UPD;
                     end else begin
                        res_status_in = STATUS_FULL;
                        state_in      = S_FIN;
                     end
                  end
               end
            end
         end

         S_UPD: begin
            ram_wr_en              = 1'b1;
            ram_wr_data.last_seen  = time_ff;
            ram_wr_data.conn_state = new_state;
            if (count_it) begin
               ram_wr_data.packets = base.packets + 32'd1;
               ram_wr_data.bytes   = base.bytes + payload_ff;
            end
            if (created_ff) begin
               valid_in[slot_ff] = 1'b1;
            end
            res_status_in  = created_ff ? STATUS_CREATED : STATUS_EXISTING;
            res_state_in   = new_state;
            res_packets_in = ram_wr_data.packets;
            res_bytes_in   = ram_wr_data.bytes;
            state_in       = S_FIN;
         end

         S_FIN: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_state_in   = res_state_ff;
               rsp_packets_in = res_packets_ff;
               rsp_bytes_in   = res_bytes_ff;
               rsp_expired_in = 7'({7'b0, exp_cnt_ff});
               if (res_status_ff == STATUS_EXISTING || res_status_ff == STATUS_CREATED) begin
                  rsp_index_in = 6'({6'b0, slot_ff});
               end else begin
                  rsp_index_in = 6'd0;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         time_ff      <= 32'd0;
         timeout_ff   <= TIMEOUT_RESET;
         valid_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         timeout_ff   <= timeout_in;
         valid_ff     <= valid_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      flags_ff       <= flags_in;
      sa_ff          <= sa_in;
      da_ff          <= da_in;
      sp_ff          <= sp_in;
      dp_ff          <= dp_in;
      payload_ff     <= payload_in;
      issue_ff       <= issue_in;
      cmp_idx_ff     <= cmp_idx_in;
      free_found_ff  <= free_found_in;
      free_slot_ff   <= free_slot_in;
      exp_cnt_ff     <= exp_cnt_in;
      slot_ff        <= slot_in;
      created_ff     <= created_in;
      hit_ff         <= hit_in;
      res_status_ff  <= res_status_in;
      res_state_ff   <= res_state_in;
      res_packets_ff <= res_packets_in;
      res_bytes_ff   <= res_bytes_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_state_ff   <= rsp_state_in;
      rsp_packets_ff <= rsp_packets_in;
      rsp_bytes_ff   <= rsp_bytes_in;
      rsp_expired_ff <= rsp_expired_in;
   end

endmodule

// ===== sv/tct_checker.sv =====
// Port-level checks of the TCP connection tracker, bound to the top level.
// Depends on tct_pkg for the response status and connection state codes.
module tct_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [5:0]  rsp_entry_index,
   input logic [2:0]  rsp_conn_state,
   input logic [31:0] rsp_packet_count,
   input logic [31:0] rsp_byte_count,
   input logic [6:0]  rsp_expired_count
);
   import tct_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_packet_count) && $stable(rsp_byte_count))
      else $error("response beat changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a request is in flight");

   a_tick_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_TICK |->
         rsp_entry_index == 6'd0 && rsp_conn_state == CONN_UNKNOWN &&
         rsp_packet_count == 32'd0 && rsp_byte_count == 32'd0)
      else $error("tick response carries session fields");

   a_drop_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_IGNORED || rsp_status == STATUS_FULL) |->
         rsp_entry_index == 6'd0 && rsp_packet_count == 32'd0 &&
         rsp_byte_count == 32'd0 && rsp_expired_count == 7'd0)
      else $error("dropped packet response carries nonzero fields");

   a_new_counters: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_CREATED |->
         rsp_packet_count == 32'd0 && rsp_byte_count == 32'd0 && rsp_expired_count == 7'd0)
      else $error("new session starts with nonzero counters");

endmodule

bind tcp_connection_tracker tct_checker u_tct_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_status        (rsp_if.status),
   .rsp_entry_index   (rsp_if.entry_index),
   .rsp_conn_state    (rsp_if.conn_state),
   .rsp_packet_count  (rsp_if.packet_count),
   .rsp_byte_count    (rsp_if.byte_count),
   .rsp_expired_count (rsp_if.expired_count)
);

// ===== test/testbench.sv =====
// Self-checking bench for tcp_connection_tracker: a directed table, then random
// session flows, ticks and noise, checked beat by beat against a local session table.
// Depends on tct_pkg and the channel interfaces in tct_if.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tct_pkg::*;

   localparam logic [3:0] SYN_BIT = 4'b0001 << FLAG_SYN;
   localparam logic [3:0] ACK_BIT = 4'b0001 << FLAG_ACK;
   localparam logic [3:0] FIN_BIT = 4'b0001 << FLAG_FIN;
   localparam logic [3:0] RST_BIT = 4'b0001 << FLAG_RST;

   localparam logic [31:0] HOST_A = 32'h0A00_0001;
   localparam logic [31:0] HOST_B = 32'hC0A8_0001;
   localparam logic [31:0] HOST_C = 32'h0A00_0102;
   localparam logic [31:0] HOST_D = 32'hAC10_2003;
   localparam logic [31:0] HOST_E = 32'h5DB8_D822;
   localparam logic [31:0] HOST_F = 32'h0808_0808;
   localparam logic [15:0] PORT_A = 16'd1234;
   localparam logic [15:0] PORT_B = 16'd80;
   localparam logic [15:0] PORT_C = 16'd8080;
   localparam int FLOWS = 12;

   typedef struct packed {
      logic        kind;
      logic [15:0] ether_type;
      logic [7:0]  ip_protocol;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [15:0] total_length;
      logic [3:0]  ip_header_words;
      logic [3:0]  tcp_header_words;
      logic [3:0]  tcp_flags;
   } tracker_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  entry_index;
      logic [2:0]  conn_state;
      logic [31:0] packet_count;
      logic [31:0] byte_count;
      logic [6:0]  expired_count;
   } tracker_rsp_type;

   typedef struct packed {
      tracker_req_type beat;
      logic            typed;
      tracker_rsp_type want;
   } directed_row_type;

   typedef struct {
      logic [31:0] client_addr;
      logic [31:0] server_addr;
      logic [15:0] client_port;
      logic [15:0] server_port;
      int          step;
      int          data_beats;
   } flow_type;

   logic clock = 1'b0;
   logic reset;

   tct_req_if req_ch();
   tct_rsp_if rsp_ch();
   tct_csr_if csr_ch();

   tcp_connection_tracker dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   entry_type   slot_info [TABLE_ENTRIES];
   logic        slot_live [TABLE_ENTRIES];
   logic [31:0] clock_secs;
   logic [15:0] idle_limit;

   tracker_rsp_type  pending_rsp[$];
   directed_row_type dir_rows[$];
   flow_type         flows [FLOWS];
   int               mismatches = 0;
   int               rsp_hold_cycles = 0;
   bit               calm = 1'b0;

   function automatic logic [2:0] advance_conn(logic [2:0] st, logic [3:0] f);
      logic s, a, fn, r;
      s  = f[FLAG_SYN];
      a  = f[FLAG_ACK];
      fn = f[FLAG_FIN];
      r  = f[FLAG_RST];
      unique case (st)
         CONN_SYN_SENT:    return (s & a) ? CONN_SYN_RECV : CONN_CLOSED;
         CONN_SYN_RECV:    return (a & ~s & ~fn & ~r) ? CONN_ESTABLISHED : CONN_CLOSED;
         CONN_ESTABLISHED: return r ? CONN_CLOSED : (fn ? CONN_FIN_WAIT1 : CONN_ESTABLISHED);
         CONN_FIN_WAIT1:   return a ? (fn ? CONN_LAST_ACK : CONN_FIN_WAIT2) : CONN_CLOSED;
         CONN_FIN_WAIT2:   return fn ? CONN_LAST_ACK : CONN_CLOSED;
         CONN_LAST_ACK:    return a ? CONN_CLOSED : CONN_LAST_ACK;
         CONN_CLOSED:      return CONN_CLOSED;
         default: begin
            if (s) return a ? CONN_SYN_RECV : CONN_SYN_SENT;
            if (fn) return CONN_FIN_WAIT1;
            return r ? CONN_CLOSED : CONN_ESTABLISHED;
         end
      endcase
   endfunction

   function automatic tracker_rsp_type track_beat(tracker_req_type b);
      tracker_rsp_type r;
      logic [31:0]     payload;
      logic [2:0]      prior;
      int              hit;
      int              gone;
      bit              created;
      r = '0;
      if (b.kind) begin
         clock_secs = clock_secs + 32'd1;
         gone = 0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_live[i] &&
                (clock_secs - slot_info[i].last_seen) > {16'b0, idle_limit}) begin
               slot_live[i] = 1'b0;
               gone++;
            end
         end
         r.status = STATUS_TICK;
         r.expired_count = gone[6:0];
         return r;
      end
      if (b.ether_type != ETHERTYPE_IPV4 || b.ip_protocol != TCP_PROTOCOL) begin
         r.status = STATUS_IGNORED;
         return r;
      end
      payload = {16'b0, b.total_length} - {26'b0, b.ip_header_words, 2'b0}
              - {26'b0, b.tcp_header_words, 2'b0};
      hit = -1;
      created = 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (hit < 0 && slot_live[i] &&
             ((slot_info[i].addr_a == b.src_addr && slot_info[i].addr_b == b.dst_addr) ||
              (slot_info[i].addr_a == b.dst_addr && slot_info[i].addr_b == b.src_addr)) &&
             ((slot_info[i].port_a == b.src_port && slot_info[i].port_b == b.dst_port) ||
              (slot_info[i].port_a == b.dst_port && slot_info[i].port_b == b.src_port)))
            hit = i;
      end
      if (hit < 0) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (hit < 0 && !slot_live[i]) hit = i;
         end
         if (hit < 0) begin
            r.status = STATUS_FULL;
            return r;
         end
         created = 1'b1;
         slot_live[hit] = 1'b1;
         slot_info[hit].addr_a = b.src_addr;
         slot_info[hit].addr_b = b.dst_addr;
         slot_info[hit].port_a = b.src_port;
         slot_info[hit].port_b = b.dst_port;
         slot_info[hit].conn_state = CONN_UNKNOWN;
         slot_info[hit].packets = '0;
         slot_info[hit].bytes = '0;
      end
      slot_info[hit].last_seen = clock_secs;
      prior = slot_info[hit].conn_state;
      slot_info[hit].conn_state = advance_conn(prior, b.tcp_flags);
      if (prior == CONN_ESTABLISHED && !b.tcp_flags[FLAG_RST]) begin
         slot_info[hit].bytes = slot_info[hit].bytes + payload;
         slot_info[hit].packets = slot_info[hit].packets + 32'd1;
      end
      r.status = created ? STATUS_CREATED : STATUS_EXISTING;
      r.entry_index = hit[5:0];
      r.conn_state = slot_info[hit].conn_state;
      r.packet_count = slot_info[hit].packets;
      r.byte_count = slot_info[hit].bytes;
      return r;
   endfunction

   function automatic tracker_rsp_type rsp_of(logic [2:0] st, logic [5:0] idx,
                                              logic [2:0] conn, logic [31:0] pk,
                                              logic [31:0] by, logic [6:0] ex);
      return '{st, idx, conn, pk, by, ex};
   endfunction

   function automatic tracker_req_type seg(logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
                                           logic [15:0] dp, logic [3:0] flags,
                                           logic [15:0] tlen = 16'd40, logic [3:0] ihl = 4'd5,
                                           logic [3:0] doff = 4'd5);
      return '{1'b0, ETHERTYPE_IPV4, TCP_PROTOCOL, sa, da, sp, dp, tlen, ihl, doff, flags};
   endfunction

   function automatic tracker_req_type retype(tracker_req_type b, logic [15:0] et,
                                              logic [7:0] pr);
      b.ether_type = et;
      b.ip_protocol = pr;
      return b;
   endfunction

   function automatic logic [31:0] pick32();
      if ($urandom_range(15) == 0) return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   function automatic logic [15:0] pick16();
      if ($urandom_range(15) == 0) return $urandom_range(1) ? 16'h0 : 16'hFFFF;
      return 16'($urandom);
   endfunction

   function automatic tracker_req_type tick_beat();
      tracker_req_type b;
      b = seg(pick32(), pick32(), pick16(), pick16(), 4'($urandom), 16'($urandom),
              4'($urandom), 4'($urandom));
      b.ether_type = 16'($urandom);
      b.ip_protocol = 8'($urandom);
      b.kind = 1'b1;
      return b;
   endfunction

   function automatic flow_type fresh_flow();
      flow_type f;
      f.client_addr = pick32();
      f.server_addr = pick32();
      f.client_port = pick16();
      f.server_port = pick16();
      f.step = 0;
      f.data_beats = $urandom_range(1, 6);
      return f;
   endfunction

   function automatic tracker_req_type seg_dir(flow_type f, bit from_client,
                                               logic [3:0] flags, logic [15:0] tlen,
                                               logic [3:0] ihl, logic [3:0] doff);
      if (from_client)
         return seg(f.client_addr, f.server_addr, f.client_port, f.server_port,
                    flags, tlen, ihl, doff);
      return seg(f.server_addr, f.client_addr, f.server_port, f.client_port,
                 flags, tlen, ihl, doff);
   endfunction

   function automatic tracker_req_type flow_beat(inout flow_type f);
      tracker_req_type b;
      logic [15:0]     tlen;
      logic [3:0]      ihl;
      logic [3:0]      doff;
      int              k;
      tlen = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(40, 1500));
      ihl  = ($urandom_range(7) == 0) ? 4'($urandom) : 4'd5;
      doff = ($urandom_range(7) == 0) ? 4'($urandom) : 4'd5;
      k = f.step - 3 - f.data_beats;
      if (f.step == 0) b = seg_dir(f, 1'b1, SYN_BIT, 16'd60, 4'd5, 4'd10);
      else if (f.step == 1) b = seg_dir(f, 1'b0, SYN_BIT | ACK_BIT, 16'd60, 4'd5, 4'd10);
      else if (f.step == 2) b = seg_dir(f, 1'b1, ACK_BIT, 16'd40, 4'd5, 4'd5);
      else if (k < 0) b = seg_dir(f, 1'($urandom_range(1)), ACK_BIT, tlen, ihl, doff);
      else if (k == 0) b = seg_dir(f, 1'b1, FIN_BIT | ACK_BIT, tlen, ihl, doff);
      else if (k == 1) b = seg_dir(f, 1'b0, ACK_BIT, 16'd40, 4'd5, 4'd5);
      else if (k == 2) b = seg_dir(f, 1'b0, FIN_BIT | ACK_BIT, 16'd40, 4'd5, 4'd5);
      else b = seg_dir(f, 1'b1, ACK_BIT, 16'd40, 4'd5, 4'd5);
      f.step++;
      if (k >= 3) f = fresh_flow();
      return b;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic send_beat(tracker_req_type b, logic typed, tracker_rsp_type want);
      tracker_rsp_type predicted;
      while (!calm && $urandom_range(99) < 20) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.kind             <= b.kind;
      req_ch.ether_type       <= b.ether_type;
      req_ch.ip_protocol      <= b.ip_protocol;
      req_ch.src_addr         <= b.src_addr;
      req_ch.dst_addr         <= b.dst_addr;
      req_ch.src_port         <= b.src_port;
      req_ch.dst_port         <= b.dst_port;
      req_ch.total_length     <= b.total_length;
      req_ch.ip_header_words  <= b.ip_header_words;
      req_ch.tcp_header_words <= b.tcp_header_words;
      req_ch.tcp_flags        <= b.tcp_flags;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predicted = track_beat(b);
      pending_rsp.push_back(typed ? want : predicted);
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_timeout(logic [15:0] secs);
      wait_for_results();
      csr_ch.valid           <= 1'b1;
      csr_ch.timeout_seconds <= secs;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      idle_limit = secs;
   endtask

   task automatic mixed_beats(int count, int tick_pct);
      tracker_req_type b;
      int              r;
      int              j;
      repeat (count) begin
         r = $urandom_range(99);
         j = $urandom_range(FLOWS - 1);
         if (r < tick_pct) begin
            b = tick_beat();
         end else if (r < tick_pct + 10) begin
            case ($urandom_range(2))
               0: b = retype(seg(pick32(), pick32(), pick16(), pick16(), 4'($urandom),
                                 16'($urandom), 4'($urandom), 4'($urandom)),
                             16'($urandom), 8'($urandom));
               1: b = retype(seg_dir(flows[j], 1'($urandom_range(1)), 4'($urandom),
                                     16'($urandom), 4'($urandom), 4'($urandom)),
                             ETHERTYPE_IPV4, 8'($urandom));
               default: b = seg_dir(flows[j], 1'($urandom_range(1)), 4'($urandom),
                                    16'($urandom), 4'($urandom), 4'($urandom));
            endcase
         end else begin
            b = flow_beat(flows[j]);
         end
         send_beat(b, 1'b0, '0);
      end
   endtask

   // response side: check every beat, idle at random, hold off on request
   initial begin
      tracker_rsp_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_rsp.size() == 0) begin
               $error("response beat with no pending result");
               mismatches++;
            end else begin
               want = pending_rsp.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_ch.status));
               check_field("entry_index", 32'(want.entry_index), 32'(rsp_ch.entry_index));
               check_field("conn_state", 32'(want.conn_state), 32'(rsp_ch.conn_state));
               check_field("packet_count", want.packet_count, rsp_ch.packet_count);
               check_field("byte_count", want.byte_count, rsp_ch.byte_count);
               check_field("expired_count", 32'(want.expired_count),
                           32'(rsp_ch.expired_count));
            end
         end
         if (rsp_hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(99) >= 20);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset                   <= 1'b1;
      req_ch.valid            <= 1'b0;
      req_ch.kind             <= 1'b0;
      req_ch.ether_type       <= '0;
      req_ch.ip_protocol      <= '0;
      req_ch.src_addr         <= '0;
      req_ch.dst_addr         <= '0;
      req_ch.src_port         <= '0;
      req_ch.dst_port         <= '0;
      req_ch.total_length     <= '0;
      req_ch.ip_header_words  <= '0;
      req_ch.tcp_header_words <= '0;
      req_ch.tcp_flags        <= '0;
      csr_ch.valid            <= 1'b0;
      csr_ch.timeout_seconds  <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         slot_live[i] = 1'b0;
         slot_info[i] = '0;
      end
      clock_secs = '0;
      idle_limit = TIMEOUT_RESET;
      foreach (flows[i]) flows[i] = fresh_flow();

      dir_rows.push_back('{tick_beat(), 1'b1, rsp_of(STATUS_TICK, 0, CONN_UNKNOWN, 0, 0, 0)});
      dir_rows.push_back('{retype(seg(HOST_A, HOST_B, PORT_A, PORT_B, SYN_BIT), 16'h86DD,
                                  TCP_PROTOCOL), 1'b1,
                           rsp_of(STATUS_IGNORED, 0, CONN_UNKNOWN, 0, 0, 0)});
      dir_rows.push_back('{retype(seg(HOST_A, HOST_B, PORT_A, PORT_B, SYN_BIT),
                                  ETHERTYPE_IPV4, 8'd17), 1'b1,
                           rsp_of(STATUS_IGNORED, 0, CONN_UNKNOWN, 0, 0, 0)});
      dir_rows.push_back('{retype(seg('1, '1, '1, '1, '1, '1, '1, '1), 16'hFFFF, 8'hFF),
                           1'b1, rsp_of(STATUS_IGNORED, 0, CONN_UNKNOWN, 0, 0, 0)});
      dir_rows.push_back('{seg(HOST_A, HOST_B, PORT_A, PORT_B, SYN_BIT), 1'b1,
                           rsp_of(STATUS_CREATED, 0, CONN_SYN_SENT, 0, 0, 0)});
      dir_rows.push_back('{seg(HOST_B, HOST_A, PORT_B, PORT_A, SYN_BIT | ACK_BIT), 1'b1,
                           rsp_of(STATUS_EXISTING, 0, CONN_SYN_RECV, 0, 0, 0)});
      dir_rows.push_back('{seg(HOST_A, HOST_B, PORT_A, PORT_B, ACK_BIT), 1'b1,
                           rsp_of(STATUS_EXISTING, 0, CONN_ESTABLISHED, 0, 0, 0)});
      dir_rows.push_back('{seg(HOST_A, HOST_B, PORT_A, PORT_B, ACK_BIT, 16'hFFFF, 4'd0, 4'd0),
                           1'b1, rsp_of(STATUS_EXISTING, 0, CONN_ESTABLISHED, 1, 65535, 0)});
      // negative payload wraps
      dir_rows.push_back('{seg(HOST_B, HOST_A, PORT_B, PORT_A, ACK_BIT, 16'd0, 4'd15, 4'd15),
                           1'b1, rsp_of(STATUS_EXISTING, 0, CONN_ESTABLISHED, 2, 65415, 0)});
      dir_rows.push_back('{seg(HOST_A, HOST_B, PORT_A, PORT_B, FIN_BIT | ACK_BIT, 16'd52,
                               4'd5, 4'd8), 1'b0, '0});
      dir_rows.push_back('{seg(HOST_B, HOST_A, PORT_B, PORT_A, ACK_BIT), 1'b0, '0});
      dir_rows.push_back('{seg(HOST_B, HOST_A, PORT_B, PORT_A, FIN_BIT | ACK_BIT), 1'b0, '0});
      dir_rows.push_back('{seg(HOST_A, HOST_B, PORT_A, PORT_B, ACK_BIT), 1'b0, '0});
      dir_rows.push_back('{seg(HOST_A, HOST_B, PORT_A, PORT_B, SYN_BIT), 1'b0, '0});
      dir_rows.push_back('{seg(32'h0, '1, 16'h0, '1, 4'b0000), 1'b1,
                           rsp_of(STATUS_CREATED, 1, CONN_ESTABLISHED, 0, 0, 0)});
      dir_rows.push_back('{seg('1, 32'h0, '1, 16'h0, RST_BIT), 1'b0, '0});
      dir_rows.push_back('{seg(HOST_C, HOST_D, PORT_A, PORT_B, FIN_BIT), 1'b1,
                           rsp_of(STATUS_CREATED, 2, CONN_FIN_WAIT1, 0, 0, 0)});
      dir_rows.push_back('{seg(HOST_D, HOST_C, PORT_C, PORT_A, RST_BIT), 1'b1,
                           rsp_of(STATUS_CREATED, 3, CONN_CLOSED, 0, 0, 0)});
      dir_rows.push_back('{seg(HOST_E, HOST_A, PORT_A, PORT_B, SYN_BIT | ACK_BIT), 1'b1,
                           rsp_of(STATUS_CREATED, 4, CONN_SYN_RECV, 0, 0, 0)});
      dir_rows.push_back('{seg(HOST_A, HOST_E, PORT_B, PORT_A, SYN_BIT | ACK_BIT), 1'b0, '0});
      // ports swapped alone, then addresses swapped alone
      dir_rows.push_back('{seg(HOST_A, HOST_B, PORT_B, PORT_A, ACK_BIT), 1'b0, '0});
      dir_rows.push_back('{seg(HOST_B, HOST_A, PORT_A, PORT_B, ACK_BIT), 1'b0, '0});
      dir_rows.push_back('{seg(HOST_F, HOST_B, PORT_A, PORT_B, SYN_BIT), 1'b0, '0});
      dir_rows.push_back('{seg(HOST_F, HOST_B, PORT_A, PORT_B, '1), 1'b0, '0});
      dir_rows.push_back('{tick_beat(), 1'b1, rsp_of(STATUS_TICK, 0, CONN_UNKNOWN, 0, 0, 0)});

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

      write_timeout(16'd0);
      mixed_beats(140, 10);

      // fill the table with no idling while the response side holds off
      write_timeout(16'hFFFF);
      calm = 1'b1;
      rsp_hold_cycles = 400;
      repeat (70) send_beat(seg(pick32(), pick32(), pick16(), pick16(), SYN_BIT), 1'b0, '0);
      mixed_beats(50, 0);
      calm = 1'b0;

      write_timeout(16'd1);
      mixed_beats(150, 15);

      write_timeout(16'($urandom_range(2, 30)));
      mixed_beats(60, 8);
      wait_for_results();
      mixed_beats(60, 8);

      wait_for_results();
      repeat (100) @(posedge clock);
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/tct_pkg.sv
sv/tct_if.sv
sv/tct_ram.sv
sv/tcp_connection_tracker.sv
sv/tct_checker.sv
test/testbench.sv
